/* hw/rtl/stream_find_replace_defines.svh */
// Assertion macros for the stream find-and-replace block.
// Used by the port-level checker; expects clk and rst in scope.
`ifndef STREAM_FIND_REPLACE_DEFINES_SVH
`define STREAM_FIND_REPLACE_DEFINES_SVH

// Checked outside reset only.
`define SFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define SFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/sfr_pkg.sv */
// Shared types and constants for the stream find-and-replace block.
// No dependencies; imported by sfr_cell, sfr_outbuf and stream_find_replace.
package sfr_pkg;

  localparam int BYTE_W = 8;
  localparam int CFG_W  = 64;
  localparam int LEN_W  = 4;
  localparam int CNT_W  = 4;

  typedef enum logic [1:0] {
    REG_PATTERN_BYTES  = 2'd0,
    REG_PATTERN_LENGTH = 2'd1,
    REG_REPL_BYTES     = 2'd2,
    REG_REPL_LENGTH    = 2'd3
  } cfg_reg_t;

  // Common control for the window cells.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  // Describes the run of result items one input item causes.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             present;
    logic             last;
  } burst_ctl_t;

endpackage

/* hw/rtl/sfr_cell.sv */
// One window cell: holds one pending text byte and compares it with its pattern byte.
// Depends on sfr_pkg.
module sfr_cell
  import sfr_pkg::*;
(
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic              sel,
  input  logic              active,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic [BYTE_W-1:0] right_byte,
  input  logic [BYTE_W-1:0] pat_byte,
  output logic [BYTE_W-1:0] win_byte,
  output logic              match
);

  logic [BYTE_W-1:0] held;

  // Window content after the incoming byte lands in its slot.
  assign win_byte = sel ? in_byte : held;
  assign match    = !active || (win_byte == pat_byte);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      held <= ctl.shift ? right_byte : win_byte;
    end
  end

endmodule

/* hw/rtl/sfr_outbuf.sv */
// Output shift buffer: holds the result items of one input item and sends one per cycle while take is high.
// Depends on sfr_pkg.
module sfr_outbuf
  import sfr_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  burst_ctl_t        ctl,
  input  logic [BYTE_W-1:0] bytes_in [DEPTH],
  input  logic              take,
  output logic              valid,
  output logic              ready,
  output logic [BYTE_W-1:0] head,
  output logic              present_o,
  output logic              end_o
);

  logic [BYTE_W-1:0] slots [DEPTH];
  logic [CNT_W-1:0]  remain;
  logic              present;
  logic              last;
  logic              pop;

  assign valid     = (remain != '0);
  assign pop       = valid && take;
  // Take a new burst when empty or while the final item of the current one leaves.
  assign ready     = !valid || ((remain == CNT_W'(1)) && take);
  assign head      = slots[0];
  assign present_o = present;
  assign end_o     = last && (remain == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
    end else if (load) begin
      remain <= ctl.count;
    end else if (pop) begin
      remain <= remain - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      present <= ctl.present;
      last    <= ctl.last;
      slots   <= bytes_in;
    end else if (pop) begin
      for (int j = 0; j < DEPTH - 1; j++) begin
        slots[j] <= slots[j+1];
      end
      slots[DEPTH-1] <= '0;
    end
  end

endmodule

/* hw/rtl/stream_find_replace.sv */
// Top level of the streaming find-and-replace block: config registers, window cells,
// burst selection and output buffer. Depends on sfr_pkg, sfr_cell and sfr_outbuf.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+---------------------------------------
//   s_*      | in        | s_tvalid/s_tready  | s_tdata = text_byte, s_tlast = text_end
//   m_*      | out       | m_tvalid/m_tready  | m_tdata = out_byte, m_tuser = present,
//            |           |                    | m_tlast = out_end
//   cfg_*    | in        | cfg_we             | cfg_addr = register, cfg_wdata = value
//
// An item's results show in the cycle after it enters, one per cycle while m_tready is high.
// An item causing zero or one result keeps the rate at one item per cycle while the output is taken;
// an item causing n results holds the input until the last of them leaves the single output port.
// A new item is taken in the cycle the last pending result is taken.
// Reset clears the config registers, the window fill and the output buffer.
module stream_find_replace
  import sfr_pkg::*;
#(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] text_byte
  input  logic              s_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // [7:0] out_byte
  output logic [0:0]        m_tuser,   // [0] byte_present
  output logic              m_tlast,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam int BUF_DEPTH = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
  localparam int FILL_W    = $clog2(MAX_PATTERN + 1);

  logic [CFG_W-1:0]  pat_bytes;
  logic [LEN_W-1:0]  pat_len;
  logic [CFG_W-1:0]  rep_bytes;
  logic [LEN_W-1:0]  rep_len;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;

  logic [LEN_W-1:0]  plen;
  logic [LEN_W-1:0]  rlen;
  logic [LEN_W-1:0]  fill_ext;
  logic              accept;
  logic              full;
  logic              match_all;
  logic              hit;
  logic              marker;
  logic [CNT_W-1:0]  cnt;

  cell_ctl_t         cell_ctl;
  burst_ctl_t        burst;
  logic [BYTE_W-1:0] win [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] match_vec;
  logic [BYTE_W-1:0] burst_bytes [BUF_DEPTH];
  logic              present;

  assign plen = (pat_len > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pat_len;
  assign rlen = (rep_len > LEN_W'(MAX_REPLACEMENT)) ? LEN_W'(MAX_REPLACEMENT) : rep_len;

  assign accept    = s_tvalid && s_tready;
  assign fill_ext  = LEN_W'(fill);
  assign full      = (plen != '0) && ((fill_ext + LEN_W'(1)) == plen);
  assign match_all = &match_vec;
  assign hit       = full && match_all;

  assign cell_ctl.load  = accept && (plen != '0);
  assign cell_ctl.shift = full && !match_all;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_bytes <= '0;
      pat_len   <= '0;
      rep_bytes <= '0;
      rep_len   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_PATTERN_BYTES:  pat_bytes <= cfg_wdata;
        REG_PATTERN_LENGTH: pat_len   <= cfg_wdata[LEN_W-1:0];
        REG_REPL_BYTES:     rep_bytes <= cfg_wdata;
        REG_REPL_LENGTH:    rep_len   <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Window cells, oldest byte in cell 0.
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [BYTE_W-1:0] right_byte;
    if (k == MAX_PATTERN - 1) begin : g_end
      assign right_byte = '0;
    end else begin : g_mid
      assign right_byte = win[k+1];
    end
    sfr_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl),
      .sel        (fill == FILL_W'(k)),
      .active     (LEN_W'(k) < plen),
      .in_byte    (s_tdata),
      .right_byte (right_byte),
      .pat_byte   (pat_bytes[k*BYTE_W +: BYTE_W]),
      .win_byte   (win[k]),
      .match      (match_vec[k])
    );
  end

  always_comb begin
    if (plen == '0) begin
      cnt       = CNT_W'(1);
      fill_next = '0;
    end else if (hit) begin
      cnt       = rlen;
      fill_next = '0;
    end else if (full) begin
      cnt       = s_tlast ? plen : CNT_W'(1);
      fill_next = s_tlast ? '0 : FILL_W'(plen - LEN_W'(1));
    end else begin
      cnt       = s_tlast ? (fill_ext + LEN_W'(1)) : '0;
      fill_next = s_tlast ? '0 : FILL_W'(fill_ext + LEN_W'(1));
    end
  end

  // A final item with nothing to send becomes a bare end marker.
  assign marker        = s_tlast && (cnt == '0);
  assign burst.count   = marker ? CNT_W'(1) : cnt;
  assign burst.present = !marker;
  assign burst.last    = s_tlast;

  for (genvar j = 0; j < BUF_DEPTH; j++) begin : g_burst
    logic [BYTE_W-1:0] win_pick;
    logic [BYTE_W-1:0] pass_pick;
    if (j < MAX_PATTERN) begin : g_win
      assign win_pick = win[j];
    end else begin : g_nowin
      assign win_pick = '0;
    end
    if (j == 0) begin : g_first
      assign pass_pick = s_tdata;
    end else begin : g_rest
      assign pass_pick = '0;
    end
    always_comb begin
      if (marker) begin
        burst_bytes[j] = '0;
      end else if (plen == '0) begin
        burst_bytes[j] = pass_pick;
      end else if (hit) begin
        burst_bytes[j] = rep_bytes[j*BYTE_W +: BYTE_W];
      end else begin
        burst_bytes[j] = win_pick;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cfg_we && (cfg_reg_t'(cfg_addr) == REG_PATTERN_LENGTH)) begin
      fill <= '0;
    end else if (accept) begin
      fill <= fill_next;
    end
  end

  sfr_outbuf #(
    .DEPTH (BUF_DEPTH)
  ) u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .ctl       (burst),
    .bytes_in  (burst_bytes),
    .take      (m_tready),
    .valid     (m_tvalid),
    .ready     (s_tready),
    .head      (m_tdata),
    .present_o (present),
    .end_o     (m_tlast)
  );

  assign m_tuser[0] = present;

endmodule

/* hw/rtl/sfr_checker.sv */
// Port-level checker for stream_find_replace, attached by the bind below.
// Depends on stream_find_replace_defines.svh for the assertion macros.
`include "stream_find_replace_defines.svh"

module sfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic [0:0]  m_tuser,
  input logic        m_tlast
);

  `SFR_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "output valid right after reset")
  `SFR_ASSERT(a_marker_form, (m_tvalid && !m_tuser[0]) |-> (m_tlast && (m_tdata == 8'h00)), "end marker item without end flag or with data")
  `SFR_ASSERT(a_idle_takes, !m_tvalid |-> s_tready, "input stalled while output empty")
  `SFR_ASSERT(a_stall_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)), "stalled output item changed")

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (.*);

/* test/tb.sv */
// Testbench for stream_find_replace: streams random and directed texts through the
// block under random back-pressure and checks every output item against a predictor.
// Depends on sfr_pkg and the stream_find_replace RTL.
module tb;
  import sfr_pkg::*;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       out_end;
  } out_item_t;

  // Predicts the rewritten text and holds the output items still to come.
  class replace_scoreboard;
    logic [63:0] pat_word;
    logic [63:0] rep_word;
    logic [3:0]  pat_len;
    logic [3:0]  rep_len;
    logic [7:0]  win [8];
    int unsigned fill;
    out_item_t   expected_out[$];
    int          errors;

    function new();
      pat_word = '0;
      rep_word = '0;
      pat_len  = '0;
      rep_len  = '0;
      fill     = 0;
      errors   = 0;
      foreach (win[i]) win[i] = '0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [63:0] v);
      case (idx)
        REG_PATTERN_BYTES: pat_word = v;
        REG_PATTERN_LENGTH: begin
          pat_len = v[3:0];
          foreach (win[i]) win[i] = '0;
          fill = 0;
        end
        REG_REPL_BYTES: rep_word = v;
        REG_REPL_LENGTH: rep_len = v[3:0];
        default: ;
      endcase
    endfunction

    function int unsigned pattern_span();
      return (pat_len > 8) ? 8 : pat_len;
    endfunction

    function void note_text_byte(logic [7:0] b, logic last);
      out_item_t   burst[$];
      int unsigned plen;
      int unsigned rlen;
      int unsigned k;
      bit          hit;
      plen = pattern_span();
      rlen = (rep_len > 8) ? 8 : rep_len;
      if (plen == 0) begin
        burst.push_back(out_item_t'{b, 1'b1, 1'b0});
        fill = 0;
      end else begin
        if (fill >= plen) fill = 0;
        win[fill] = b;
        fill++;
        if (fill == plen) begin
          hit = 1'b1;
          for (k = 0; k < plen; k++)
            if (win[k] != pat_word[8*k +: 8]) hit = 1'b0;
          if (hit) begin
            for (k = 0; k < rlen; k++)
              burst.push_back(out_item_t'{rep_word[8*k +: 8], 1'b1, 1'b0});
            fill = 0;
          end else begin
            burst.push_back(out_item_t'{win[0], 1'b1, 1'b0});
            for (k = 1; k < plen; k++) win[k-1] = win[k];
            fill = plen - 1;
          end
        end
        if (last) begin
          for (k = 0; k < fill; k++) burst.push_back(out_item_t'{win[k], 1'b1, 1'b0});
          fill = 0;
        end
      end
      // the end of a text always yields an item, an empty marker if nothing else
      if (last) begin
        if (burst.size() == 0) burst.push_back(out_item_t'{8'h00, 1'b0, 1'b1});
        else burst[burst.size()-1].out_end = 1'b1;
      end
      foreach (burst[i]) expected_out.push_back(burst[i]);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        if (errors < 40) $display("%0t: %s expected %02h got %02h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_out_item(logic [7:0] d, logic p, logic e);
      out_item_t want;
      if (expected_out.size() == 0) begin
        if (errors < 40)
          $display("%0t: item expected none got byte %02h present %b end %b",
                   $time, d, p, e);
        errors++;
      end else begin
        want = expected_out.pop_front();
        compare_field("out_byte", want.out_byte, d);
        compare_field("byte_present", {7'd0, want.byte_present}, {7'd0, p});
        compare_field("out_end", {7'd0, want.out_end}, {7'd0, e});
      end
    endfunction

    function int pending();
      return expected_out.size();
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;   // [7:0] text_byte
  logic        s_tlast   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [7:0]  m_tdata;          // [7:0] out_byte
  logic [0:0]  m_tuser;          // [0] byte_present
  logic        m_tlast;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_addr  = '0;
  logic [63:0] cfg_wdata = '0;

  replace_scoreboard sb = new();

  int          src_idle  = 0;
  int          snk_stall = 0;
  bit          hold_req  = 1'b0;
  bit          hold_off  = 1'b0;
  logic [7:0]  text_buf[$];

  stream_find_replace u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Long receiver hold-off so the block fills up and stalls its input.
  always begin
    wait (hold_req);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
    hold_req = 1'b0;
  end

  always @(negedge clk)
    m_tready = !hold_off && ($urandom_range(0, 99) >= snk_stall);

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) sb.check_out_item(m_tdata, m_tuser[0], m_tlast);

  task automatic send_item(logic [7:0] b, logic last);
    while ($urandom_range(0, 99) < src_idle) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tlast  = last;
    do @(posedge clk); while (!s_tready);
    sb.note_text_byte(b, last);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // Hold the sender until every expected item is out.
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [63:0] v);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = v;
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_text();
    int i;
    for (i = 0; i < text_buf.size(); i++) send_item(text_buf[i], i == text_buf.size() - 1);
  endtask

  // Mix whole pattern copies, pattern prefixes, pattern symbols and random noise.
  task automatic build_text();
    int unsigned plen;
    int unsigned want;
    int unsigned r;
    int unsigned n;
    int unsigned k;
    text_buf.delete();
    plen = sb.pattern_span();
    want = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 14);
    while (text_buf.size() < want) begin
      r = $urandom_range(0, 99);
      if (plen != 0 && r < 30) n = plen;
      else if (plen > 1 && r < 45) n = $urandom_range(1, plen - 1);
      else n = 0;
      if (n != 0) begin
        for (k = 0; k < n; k++) text_buf.push_back(sb.pat_word[8*k +: 8]);
      end else if (plen != 0 && r < 90) begin
        k = $urandom_range(0, plen - 1);
        text_buf.push_back(sb.pat_word[8*k +: 8]);
      end else begin
        text_buf.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Negative length codes pick a random length, saturating values included.
  task automatic setup(int plen_code, int rlen_code);
    logic [63:0] pat;
    logic [7:0]  sym_a;
    logic [7:0]  sym_b;
    logic [3:0]  plen;
    logic [3:0]  rlen;
    int          k;
    sym_a = 8'($urandom);
    sym_b = 8'($urandom);
    for (k = 0; k < 8; k++)
      pat[8*k +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                      ($urandom_range(0, 1) ? sym_a : sym_b);
    plen = 4'((plen_code < 0) ? $urandom_range(0, 15) : plen_code);
    rlen = 4'((rlen_code < 0) ? $urandom_range(0, 15) : rlen_code);
    write_reg(REG_PATTERN_BYTES, pat);
    write_reg(REG_REPL_BYTES, {$urandom, $urandom});
    write_reg(REG_PATTERN_LENGTH, {$urandom, 28'($urandom), plen});
    write_reg(REG_REPL_LENGTH, {$urandom, 28'($urandom), rlen});
  endtask

  task automatic run_phase(int src, int snk, int plen_code, int rlen_code, int n_items,
                           bit squeeze);
    int sent;
    drain();
    setup(plen_code, rlen_code);
    src_idle  = src;
    snk_stall = snk;
    if (squeeze) hold_req = 1'b1;
    sent = 0;
    while (sent < n_items) begin
      build_text();
      send_text();
      sent += text_buf.size();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // zero pattern length after reset: pass-through
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hA5, 1'b1);
    send_item(8'h5A, 1'b1);
    drain();

    write_reg(REG_PATTERN_BYTES, 64'h6261);
    write_reg(REG_PATTERN_LENGTH, 64'd2);
    write_reg(REG_REPL_BYTES, 64'h5A5958);
    write_reg(REG_REPL_LENGTH, 64'd3);
    send_item(8'h61, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b1);
    send_item(8'h62, 1'b1);
    drain();

    // empty replacement on the final bytes: empty end marker
    write_reg(REG_REPL_LENGTH, 64'd0);
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b1);
    drain();

    // saturated lengths, full-width match with the longest replacement
    write_reg(REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_PATTERN_LENGTH, 64'hF);
    write_reg(REG_REPL_BYTES, 64'h0123_4567_89AB_CDEF);
    write_reg(REG_REPL_LENGTH, 64'hF);
    repeat (7) send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b1);
    drain();

    // pattern length rewritten mid-text drops the pending bytes
    write_reg(REG_PATTERN_BYTES, 64'h7A7978);
    write_reg(REG_PATTERN_LENGTH, 64'd3);
    send_item(8'h78, 1'b0);
    send_item(8'h79, 1'b0);
    drain();
    write_reg(REG_PATTERN_LENGTH, 64'd3);
    send_item(8'h7A, 1'b1);

    run_phase(0, 0, 2, 8, 34, 1'b1);
    run_phase(0, 0, 15, 1, 34, 1'b0);
    run_phase(78, 0, 1, 0, 34, 1'b0);
    run_phase(78, 0, -1, -1, 34, 1'b0);
    run_phase(0, 78, 8, 15, 34, 1'b0);
    run_phase(0, 78, 0, 3, 34, 1'b0);
    run_phase(19, 19, 9, -1, 34, 1'b0);
    run_phase(19, 19, -1, -1, 34, 1'b0);

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

  initial begin
    #3000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
